/* rtl/wpm_pkg.sv */
package wpm_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int MAX_TEXT_DEF    = 65536;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] WILDCARD = 8'h2A;

  localparam int CFG_DATA_W = 7;

  typedef enum logic {
    REG_PATTERN_LENGTH = 1'b0,
    REG_OVERLAP_MODE   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       func;
    logic [5:0] pattern_index;
    logic [7:0] data_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [15:0] match_start;
    logic [15:0] match_end;
    logic [15:0] match_count;
  } result_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SKIP = 2'd1,
    OP_TEXT = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [5:0] idx;
    logic [7:0] data;
    logic       eot;
  } op_t;

endpackage

/* rtl/wpm_fifo.sv */
module wpm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/wpm_front.sv */
module wpm_front #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  wpm_pkg::item_t item,
  output logic          op_valid,
  output wpm_pkg::op_t  op,
  input  logic          op_pop
);
  import wpm_pkg::*;

  op_t  op_in;
  logic q_empty;
  logic [$bits(op_t)-1:0] q_out;

  // sort each item by what the matcher must do with it
  always_comb begin
    op_in.idx  = item.pattern_index;
    op_in.data = item.data_byte;
    op_in.eot  = item.end_of_text;
    if (item.func) begin
      op_in.kind = OP_TEXT;
    end else if (32'(item.pattern_index) < MAX_PATTERN) begin
      op_in.kind = OP_LOAD;
    end else begin
      op_in.kind = OP_SKIP;
    end
  end

  wpm_fifo #(
    .W     ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (op_in),
    .full    (full),
    .rd_en   (op_pop),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  assign op_valid = !q_empty;
  assign op       = op_t'(q_out);

endmodule

/* rtl/wpm_back.sv */
module wpm_back #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = wpm_pkg::MAX_TEXT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wpm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           op_valid,
  input  wpm_pkg::op_t                   op,
  output logic                           op_pop,
  input  logic                           res_full,
  output logic                           res_push,
  output wpm_pkg::result_t               res
);
  import wpm_pkg::*;

  localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int XW  = (PIW > 6) ? PIW : 6;
  localparam int PW  = $clog2(MAX_TEXT + 1);
  localparam int CW  = ((PW > 7) ? PW : 7) + 1;
  localparam int SW  = $clog2(MAX_PATTERN + 1) + 1;
  localparam int VW  = MAX_PATTERN * 8;

  logic [6:0]    len;
  logic          overlap;
  logic [7:0]    pat [MAX_PATTERN];
  logic [7:0]    win [MAX_PATTERN];
  logic [PW-1:0] pos;
  logic [PW-1:0] last_end;
  logic          have_acc;
  logic [15:0]   count;

  logic [7:0]    win_shift [MAX_PATTERN];
  logic [7:0]    win_next  [MAX_PATTERN];
  logic [PW-1:0] pos_next;
  logic [PW-1:0] last_end_next;
  logic          have_acc_next;
  logic [15:0]   count_next;
  logic [15:0]   count_inc;

  logic          text_step;
  logic          load_step;
  logic          in_range;
  logic [XW-1:0] idx_x;
  logic [PIW-1:0] widx;
  logic [VW-1:0] wv;
  logic [VW-1:0] aligned;
  logic [SW-1:0] sh;
  logic [MAX_PATTERN-1:0] hit;
  logic          len_ok;
  logic [CW-1:0] pos1;
  logic [CW-1:0] start_x;
  logic          window_hit;
  logic          accept;

  assign op_pop    = op_valid && !res_full;
  assign text_step = op_pop && (op.kind == OP_TEXT);
  assign load_step = op_pop && (op.kind == OP_LOAD);
  assign in_range  = (pos < PW'(MAX_TEXT));
  assign idx_x     = XW'(op.idx);
  assign widx      = idx_x[PIW-1:0];

  // newest byte enters at the top of the window
  always_comb begin
    for (int j = 0; j < MAX_PATTERN - 1; j++) begin
      win_shift[j] = win[j + 1];
    end
    win_shift[MAX_PATTERN - 1] = op.data;
  end

  // line up the newest len bytes with pattern positions 0 .. len-1
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      wv[j*8 +: 8] = win_shift[j];
    end
    sh      = SW'(MAX_PATTERN) - SW'(len);
    aligned = wv >> {sh, 3'b000};
    for (int k = 0; k < MAX_PATTERN; k++) begin
      hit[k] = (k >= 32'(len)) || (pat[k] == WILDCARD) || (pat[k] == aligned[k*8 +: 8]);
    end
  end

  assign len_ok     = (len != '0) && (32'(len) <= MAX_PATTERN);
  assign pos1       = CW'(pos) + 1'b1;
  assign start_x    = pos1 - CW'(len);
  assign window_hit = len_ok && (pos1 >= CW'(len)) && (&hit);
  assign accept     = window_hit && (overlap || !have_acc || (start_x > CW'(last_end)));
  assign res_push   = text_step && in_range && accept;
  assign count_inc  = (count != 16'hFFFF) ? count + 1'b1 : count;

  always_comb begin
    res.match_start = 16'(start_x);
    res.match_end   = 16'(pos);
    res.match_count = count_inc;
  end

  always_comb begin
    win_next      = win;
    pos_next      = pos;
    last_end_next = last_end;
    have_acc_next = have_acc;
    count_next    = count;
    if (in_range) begin
      win_next = win_shift;
      pos_next = pos + 1'b1;
      if (accept) begin
        have_acc_next = 1'b1;
        last_end_next = pos;
        count_next    = count_inc;
      end
    end
    // clear after the final byte of a text has been looked at
    if (op.eot) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_next[j] = '0;
      end
      pos_next      = '0;
      last_end_next = '0;
      have_acc_next = 1'b0;
      count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_step) begin
      pat[widx] <= op.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      overlap  <= 1'b0;
      pos      <= '0;
      last_end <= '0;
      have_acc <= 1'b0;
      count    <= '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PATTERN_LENGTH: len     <= cfg_data;
          REG_OVERLAP_MODE:   overlap <= cfg_data[0];
        endcase
      end
      if (text_step) begin
        win      <= win_next;
        pos      <= pos_next;
        last_end <= last_end_next;
        have_acc <= have_acc_next;
        count    <= count_next;
      end
    end
  end

  a_push_only_text: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (op_valid && !res_full && op.kind == OP_TEXT))
    else $error("result pushed for a non-text transaction");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (text_step && op.eot) |=> (pos == '0 && !have_acc && count == '0))
    else $error("text state not cleared after end of text");

  a_count_flag: assert property (@(posedge clk) disable iff (rst)
    !have_acc |-> (count == '0))
    else $error("match count without an accepted match");

  a_load_holds_text: assert property (@(posedge clk) disable iff (rst)
    (op_pop && op.kind != OP_TEXT) |=> $stable(pos) && $stable(count))
    else $error("text state moved on a pattern transaction");

endmodule

/* rtl/wildcard_pattern_matcher.sv */
// A text byte is queued, matched and its result registered in the result queue
// before it can be popped. One item per cycle while the result queue is not full,
// pattern loads included; window shift and wildcard compare are combinational.
// Reset (synchronous, rst high): queues empty, window, position, counts and
// both configuration registers cleared; the pattern store keeps its contents.
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = wpm_pkg::MAX_TEXT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  wpm_pkg::item_t                 item,
  output logic                           empty,
  input  logic                           pop,
  output wpm_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [wpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wpm_pkg::*;

  logic    op_valid;
  op_t     op;
  logic    op_pop;
  logic    res_full;
  logic    res_push;
  result_t res;
  logic [$bits(result_t)-1:0] res_bits;

  assign cfg_ready = 1'b1;

  wpm_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  wpm_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  wpm_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign result = result_t'(res_bits);

endmodule
